/* design/stbl_pkg.sv */
`default_nettype none

package stbl_pkg;

  // Opcodes of a request.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BLUR_RADIUS  = 2'd2;

  // Field widths fixed by the interface.
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned PixW     = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;

  typedef struct packed {
    logic            opcode;
    logic [PixW-1:0] pixel_in;
  } stbl_req_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_out;
    logic            valid_res;
    logic            last_pixel;
  } stbl_res_t;

  // Host access to the frame store while the blur engine is idle.
  typedef struct packed {
    logic load;
    logic read;
  } stbl_host_t;

endpackage

`default_nettype wire

/* design/stbl_div.sv */
`default_nettype none

module stbl_div
  import stbl_pkg::*;
#(
  parameter int unsigned SUM_W = 19
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [SUM_W-1:0]                divisor_i,
  input  wire logic [NumChan-1:0][SUM_W-1:0]   sum_i,
  output logic      [NumChan-1:0][ChanW-1:0]   quot_o,
  output logic                                 done_o
);

  logic [NumChan-1:0][SUM_W-1:0] rem_q, rem_d;
  logic [NumChan-1:0][ChanW-1:0] quot_q, quot_d;
  logic [SUM_W-1:0]              dsh_q, dsh_d;
  logic [2:0]                    cnt_q, cnt_d;
  logic                          run_q, run_d;
  logic                          done_q, done_d;

  // One restoring step per cycle, all three channels share the divisor.
  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    dsh_d  = dsh_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = sum_i;
      quot_d = '0;
      dsh_d  = divisor_i << (ChanW - 1);
      cnt_d  = 3'(ChanW - 1);
      run_d  = 1'b1;
    end else if (run_q) begin
      for (int c = 0; c < NumChan; c++) begin
        if (rem_q[c] >= dsh_q) begin
          rem_d[c]  = rem_q[c] - dsh_q;
          quot_d[c] = {quot_q[c][ChanW-2:0], 1'b1};
        end else begin
          quot_d[c] = {quot_q[c][ChanW-2:0], 1'b0};
        end
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dsh_q  <= dsh_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* design/stbl_engine.sv */
`default_nettype none

module stbl_engine
  import stbl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_RADIUS = 32,
  parameter int unsigned DIM_W      = 9,
  parameter int unsigned R_W        = 6,
  parameter int unsigned A_W        = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              go_i,
  input  wire logic [DIM_W-1:0]  width_i,
  input  wire logic [DIM_W-1:0]  height_i,
  input  wire logic [R_W-1:0]    radius_i,
  input  wire stbl_host_t        host_i,
  input  wire logic [A_W-1:0]    host_addr_i,
  input  wire logic [PixW-1:0]   host_pix_i,
  output logic [PixW-1:0]        host_rdata_o,
  output logic                   busy_o,
  output logic                   done_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned RgbW  = NumChan * ChanW;
  localparam int unsigned K_W   = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned WT_W  = $clog2(MAX_RADIUS + 2);
  localparam int unsigned SUM_W = $clog2(255 * (MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);
  localparam int unsigned OFF_W = ((DIM_W > R_W) ? DIM_W : R_W) + 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PIX, ST_RD, ST_LAST, ST_DIV, ST_WAIT, ST_WR
  } state_e;

  // Frame store keeps loaded pixels and later the final result.
  logic [PixW-1:0] frame_mem [Depth];
  logic [RgbW-1:0] row_mem   [Depth];

  state_e                      state_q;
  logic                        pass_q;
  logic [DIM_W-1:0]            line_q, pos_q;
  logic [A_W-1:0]              base_q;
  logic [K_W-1:0]              k_q;
  logic [WT_W-1:0]             wt_q, acc_w_q;
  logic                        acc_en_q;
  logic signed [OFF_W-1:0]     off_q;
  logic [NumChan-1:0][SUM_W-1:0] sum_q;
  logic [SUM_W-1:0]            div_q;
  logic [ChanW-1:0]            alpha_q;
  logic [PixW-1:0]             frame_rd_q;
  logic [RgbW-1:0]             row_rd_q;

  logic [DIM_W-1:0]            len, lines, at, m_a;
  logic [2*DIM_W-1:0]          prod;
  logic [A_W-1:0]              addr;
  logic [RgbW-1:0]             sample;
  logic [K_W-1:0]              k_end;
  logic [NumChan-1:0][ChanW-1:0] quot;
  logic                        div_done;
  logic                        frame_we, row_we;
  logic [A_W-1:0]              frame_waddr, frame_raddr;
  logic [PixW-1:0]             frame_wdata;

  assign len   = pass_q ? height_i : width_i;
  assign lines = pass_q ? width_i  : height_i;
  assign k_end = K_W'({radius_i, 1'b0});

  // Clamp the window position to the line.
  always_comb begin
    if (off_q < 0) begin
      at = '0;
    end else if (off_q > OFF_W'(signed'({1'b0, len - DIM_W'(1)}))) begin
      at = len - DIM_W'(1);
    end else begin
      at = off_q[DIM_W-1:0];
    end
  end

  // Address of a sample or of the destination pixel.
  assign m_a  = (state_q == ST_RD) ? at : pos_q;
  assign prod = m_a * width_i;
  assign addr = pass_q ? A_W'(prod + (2*DIM_W)'(line_q)) : base_q + A_W'(m_a);

  assign sample = pass_q ? row_rd_q : frame_rd_q[RgbW-1:0];

  // Memory ports.
  assign frame_we    = (state_q == ST_IDLE) ? host_i.load : (state_q == ST_WR && pass_q);
  assign frame_waddr = (state_q == ST_IDLE) ? host_addr_i : addr;
  assign frame_wdata = (state_q == ST_IDLE) ? host_pix_i : {alpha_q, quot[2], quot[1], quot[0]};
  assign frame_raddr = (state_q == ST_IDLE) ? host_addr_i : addr;
  assign row_we      = (state_q == ST_WR) && !pass_q;

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[frame_waddr] <= frame_wdata;
    end
    if (row_we) begin
      row_mem[addr] <= {quot[2], quot[1], quot[0]};
    end
    frame_rd_q <= frame_mem[frame_raddr];
    row_rd_q   <= row_mem[addr];
  end

  stbl_div #(.SUM_W(SUM_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ST_DIV),
    .divisor_i (div_q),
    .sum_i     (sum_q),
    .quot_o    (quot),
    .done_o    (div_done)
  );

  // Sequencer: each pixel walks its window, then divides and writes back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      acc_en_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      acc_en_q <= 1'b0;
      done_o   <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (go_i) begin
            pass_q  <= 1'b0;
            line_q  <= '0;
            pos_q   <= '0;
            base_q  <= '0;
            div_q   <= SUM_W'((R_W+1)'(radius_i) + 1'b1) * SUM_W'((R_W+1)'(radius_i) + 1'b1);
            state_q <= ST_PIX;
          end
        end
        ST_PIX: begin
          off_q   <= OFF_W'(signed'({1'b0, pos_q})) - OFF_W'(signed'({1'b0, radius_i}));
          k_q     <= '0;
          wt_q    <= WT_W'(1);
          sum_q   <= '0;
          state_q <= ST_RD;
        end
        ST_RD: begin
          acc_en_q <= 1'b1;
          acc_w_q  <= wt_q;
          off_q    <= off_q + OFF_W'(1);
          k_q      <= k_q + K_W'(1);
          if (k_q < K_W'(radius_i)) begin
            wt_q <= wt_q + WT_W'(1);
          end else begin
            wt_q <= wt_q - WT_W'(1);
          end
          if (k_q == k_end) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          alpha_q <= frame_rd_q[PixW-1:RgbW];
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            state_q <= ST_WR;
          end
        end
        ST_WR: begin
          state_q <= ST_PIX;
          if (pos_q == len - DIM_W'(1)) begin
            pos_q <= '0;
            if (line_q == lines - DIM_W'(1)) begin
              line_q <= '0;
              base_q <= '0;
              if (!pass_q) begin
                pass_q <= 1'b1;
              end else begin
                state_q <= ST_IDLE;
                done_o  <= 1'b1;
              end
            end else begin
              line_q <= line_q + DIM_W'(1);
              base_q <= base_q + A_W'(width_i);
            end
          end else begin
            pos_q <= pos_q + DIM_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // Weighted sum of the sample fetched in the previous cycle.
      if (acc_en_q) begin
        for (int c = 0; c < NumChan; c++) begin
          sum_q[c] <= sum_q[c] + SUM_W'(sample[ChanW*c +: ChanW] * acc_w_q);
        end
      end
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign host_rdata_o = frame_rd_q;

endmodule

`default_nettype wire

/* design/stack_blur_argb_core.sv */
`default_nettype none

// Stack blur of one ARGB frame, loaded one pixel per request.
// A read request gives its result in the next cycle, one per cycle while busy is low.
// The final load starts the blur, which holds busy through both passes, as each pixel
// walks its window and then waits for the 8-step divider. A configuration write also
// holds busy while the effective sizes settle. Results cannot be stalled. Reset clears
// the counters and sets width 256, height 256, radius 1.
module stack_blur_argb_core
  import stbl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_RADIUS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire stbl_req_t            req_i,
  output stbl_res_t                 res_o,
  output logic                      res_valid_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned MaxDim = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DIM_W  = $clog2(MaxDim + 1);
  localparam int unsigned R_W    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned A_W    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned N_W    = $clog2(Depth + 1);

  logic [CfgDataW-1:0] cfg_w_q, cfg_h_q;
  logic [5:0]          cfg_r_q;
  logic [DIM_W-1:0]    w_eff_q, h_eff_q;
  logic [R_W-1:0]      r_eff_q;
  logic [N_W-1:0]      n_q;
  logic [1:0]          settle_q;
  logic [N_W-1:0]      lc_q, rc_q, lc_base, lc_new;
  logic                done_q, go_q;
  logic                rv_q, rvalid_q, rlast_q;
  logic                accept, cfg_wr;
  logic                eng_busy, eng_done;
  stbl_host_t          host;
  logic [A_W-1:0]      host_addr;
  logic [PixW-1:0]     rdata;

  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_FRAME_WIDTH ||
                       cfg_index_i == CFG_FRAME_HEIGHT || cfg_index_i == CFG_BLUR_RADIUS);
  // The cycle in which the engine reports completion is still busy, so that the
  // finished flag is set before the next request is looked at.
  assign busy        = (settle_q != 2'd0) || go_q || eng_busy || eng_done;

  // Load bookkeeping: a load after a finished blur starts a new frame.
  assign lc_base = done_q ? '0 : lc_q;
  assign lc_new  = (lc_base < n_q) ? lc_base + N_W'(1) : lc_base;

  always_comb begin
    host.load = accept && (req_i.opcode == OP_LOAD) && (lc_base < n_q);
    host.read = accept && (req_i.opcode == OP_READ) && done_q && (rc_q < n_q);
    host_addr = (req_i.opcode == OP_LOAD) ? A_W'(lc_base) : A_W'(rc_q);
  end

  // Effective sizes, pipelined behind the configuration registers.
  always_ff @(posedge clk_i) begin
    if (cfg_w_q == '0) begin
      w_eff_q <= DIM_W'(1);
    end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
      w_eff_q <= DIM_W'(MAX_WIDTH);
    end else begin
      w_eff_q <= DIM_W'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff_q <= DIM_W'(1);
    end else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) begin
      h_eff_q <= DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff_q <= DIM_W'(cfg_h_q);
    end
    if (32'(cfg_r_q) > 32'(MAX_RADIUS)) begin
      r_eff_q <= R_W'(MAX_RADIUS);
    end else begin
      r_eff_q <= R_W'(cfg_r_q);
    end
    n_q <= N_W'(w_eff_q) * N_W'(h_eff_q);
  end

  // Configuration, counters and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= CfgDataW'(256);
      cfg_h_q  <= CfgDataW'(256);
      cfg_r_q  <= 6'd1;
      settle_q <= 2'd3;
      lc_q     <= '0;
      rc_q     <= '0;
      done_q   <= 1'b0;
      go_q     <= 1'b0;
      rv_q     <= 1'b0;
      rvalid_q <= 1'b0;
      rlast_q  <= 1'b0;
    end else begin
      go_q <= 1'b0;
      rv_q <= 1'b0;
      if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
      if (eng_done) begin
        done_q <= 1'b1;
      end
      if (cfg_wr) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:  cfg_w_q <= cfg_data_i;
          CFG_FRAME_HEIGHT: cfg_h_q <= cfg_data_i;
          CFG_BLUR_RADIUS:  cfg_r_q <= cfg_data_i[5:0];
          default: ;
        endcase
        settle_q <= 2'd3;
        lc_q     <= '0;
        rc_q     <= '0;
        done_q   <= 1'b0;
      end else if (accept && req_i.opcode == OP_LOAD) begin
        if (done_q) begin
          rc_q   <= '0;
          done_q <= 1'b0;
        end
        lc_q <= lc_new;
        if (lc_new >= n_q) begin
          go_q <= 1'b1;
        end
      end else if (accept) begin
        rv_q     <= 1'b1;
        rvalid_q <= host.read;
        rlast_q  <= host.read && (rc_q == n_q - N_W'(1));
        if (host.read) begin
          rc_q <= rc_q + N_W'(1);
        end
      end
    end
  end

  stbl_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .DIM_W      (DIM_W),
    .R_W        (R_W),
    .A_W        (A_W)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (go_q),
    .width_i      (w_eff_q),
    .height_i     (h_eff_q),
    .radius_i     (r_eff_q),
    .host_i       (host),
    .host_addr_i  (host_addr),
    .host_pix_i   (req_i.pixel_in),
    .host_rdata_o (rdata),
    .busy_o       (eng_busy),
    .done_o       (eng_done)
  );

  assign res_valid_o      = rv_q;
  assign res_o.pixel_out  = rvalid_q ? rdata : '0;
  assign res_o.valid_res  = rvalid_q;
  assign res_o.last_pixel = rlast_q;

endmodule

`default_nettype wire

/* verif/stack_blur_argb_core_tb.sv */
module stack_blur_argb_core_tb;
  import stbl_pkg::*;

  localparam int unsigned MaxDim    = 256;
  localparam int unsigned MaxRad    = 32;
  localparam int unsigned StallMax  = 200000;
  localparam logic [1:0]  CFG_UNUSED = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  stbl_req_t           req_i;
  stbl_res_t           res_o;
  logic                res_valid_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  stack_blur_argb_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock with a period of 10.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the block state used to predict blurred pixels.
  logic [31:0] frame_mem [MaxDim*MaxDim];
  logic [23:0] row_mem [MaxDim*MaxDim];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [5:0]  radius_reg;
  int unsigned load_cnt;
  int unsigned read_cnt;
  bit          blurred;

  stbl_res_t   pending_pixels [$];
  int unsigned mismatch_cnt;
  bit          idle_en;

  function automatic int unsigned eff_dim(logic [8:0] v);
    if (v == 0) return 1;
    return (v > MaxDim) ? MaxDim : int'(v);
  endfunction

  // Blur one line; the vertical pass reads the row results and keeps the alpha.
  task automatic blur_line(bit vert, int unsigned base, int unsigned stride,
                           int unsigned len, int unsigned rad);
    int unsigned divisor;
    int unsigned at;
    int unsigned wgt;
    int unsigned sum [3];
    logic [23:0] smp;
    logic [23:0] rgb;
    divisor = (rad + 1) * (rad + 1);
    for (int unsigned pos = 0; pos < len; pos++) begin
      sum = '{0, 0, 0};
      for (int unsigned k = 0; k <= 2 * rad; k++) begin
        at = (pos + k < rad) ? 0 : pos + k - rad;
        if (at > len - 1) at = len - 1;
        smp = vert ? row_mem[base + at * stride] : frame_mem[base + at * stride][23:0];
        wgt = (k <= rad) ? k + 1 : 2 * rad + 1 - k;
        for (int c = 0; c < 3; c++) sum[c] += smp[8*c +: 8] * wgt;
      end
      for (int c = 0; c < 3; c++) rgb[8*c +: 8] = sum[c] / divisor;
      if (vert) frame_mem[base + pos * stride][23:0] = rgb;
      else row_mem[base + pos * stride] = rgb;
    end
  endtask

  task automatic blur_frame();
    int unsigned w;
    int unsigned h;
    int unsigned rad;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    rad = (radius_reg > MaxRad) ? MaxRad : radius_reg;
    for (int unsigned i = 0; i < h; i++) blur_line(1'b0, i * w, 1, w, rad);
    for (int unsigned i = 0; i < w; i++) blur_line(1'b1, i, w, h, rad);
    blurred = 1'b1;
  endtask

  // Update the shadow state for one accepted request.
  task automatic predict_request(stbl_req_t r);
    int unsigned n;
    stbl_res_t   exp_pix;
    n = eff_dim(width_reg) * eff_dim(height_reg);
    if (r.opcode == OP_LOAD) begin
      if (blurred) begin
        load_cnt = 0;
        read_cnt = 0;
        blurred = 1'b0;
      end
      if (load_cnt < n) begin
        frame_mem[load_cnt] = r.pixel_in;
        load_cnt++;
      end
      if (load_cnt >= n) blur_frame();
    end else begin
      exp_pix = '0;
      if (blurred && read_cnt < n) begin
        exp_pix.pixel_out  = frame_mem[read_cnt];
        exp_pix.valid_res  = 1'b1;
        exp_pix.last_pixel = (read_cnt == n - 1);
        read_cnt++;
      end
      pending_pixels.push_back(exp_pix);
    end
  endtask

  // Send one request, with an occasional gap before it.
  task automatic send_request(logic op, logic [31:0] pix);
    stbl_req_t r;
    r.opcode = op;
    r.pixel_in = pix;
    if (idle_en && $urandom_range(99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_request(r);
  endtask

  // Let the block drain so that a register can be written safely.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = data;
      CFG_FRAME_HEIGHT: height_reg = data;
      CFG_BLUR_RADIUS:  radius_reg = data[5:0];
      default: return;
    endcase
    load_cnt = 0;
    read_cnt = 0;
    blurred = 1'b0;
  endtask

  task automatic set_frame(logic [8:0] w, logic [8:0] h, logic [8:0] rad);
    settle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_BLUR_RADIUS, rad);
  endtask

  // Load a whole frame of random pixels, then read it back plus a spare read.
  task automatic run_frame(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_request(OP_LOAD, $urandom);
    for (int unsigned i = 0; i <= n; i++) send_request(OP_READ, $urandom);
  endtask

  // Reads before any frame, then a small frame with extreme pixel values.
  task automatic test_basic_frame();
    send_request(OP_READ, 32'hffff_ffff);
    set_frame(9'd2, 9'd2, 9'd1);
    send_request(OP_READ, '0);
    send_request(OP_LOAD, 32'hffff_ffff);
    send_request(OP_LOAD, 32'h0000_0000);
    send_request(OP_LOAD, 32'h00ff_00ff);
    send_request(OP_LOAD, 32'hff00_ff00);
    repeat (5) send_request(OP_READ, '0);
    // A load after a blurred frame starts the next frame.
    run_frame(4);
  endtask

  // Zero sizes, zero radius, unused index and an aborted frame.
  task automatic test_special_cases();
    set_frame(9'd0, 9'd0, 9'd0);
    run_frame(1);
    set_frame(9'd3, 9'd1, 9'd0);
    write_reg(CFG_UNUSED, 9'h1ff);
    run_frame(3);
    set_frame(9'd2, 9'd3, 9'd2);
    send_request(OP_LOAD, $urandom);
    send_request(OP_LOAD, $urandom);
    settle();
    write_reg(CFG_BLUR_RADIUS, 9'd3);
    run_frame(6);
  endtask

  // Largest row and column with oversized settings that saturate.
  task automatic test_extremes();
    idle_en = 1'b0;
    set_frame(9'd300, 9'd0, 9'h1ff);
    run_frame(MaxDim);
    idle_en = 1'b1;
    set_frame(9'd1, 9'd256, 9'd32);
    // Only the top of the column is read back before the next frame aborts it.
    for (int unsigned i = 0; i < MaxDim; i++) send_request(OP_LOAD, $urandom);
    for (int unsigned i = 0; i < 40; i++) send_request(OP_READ, $urandom);
  endtask

  // Mostly complete small frames with random content, some noise and aborts.
  task automatic test_random_frames();
    int unsigned n;
    int unsigned sent;
    sent = 0;
    while (sent < 40) begin
      idle_en = 1'b1;
      set_frame($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 8));
      n = eff_dim(width_reg) * eff_dim(height_reg);
      if ($urandom_range(9) == 0) begin
        // Broken frame: partial load with reads that find nothing ready.
        for (int unsigned i = 0; i < n / 2 + 1 && i < n - 1; i++) begin
          send_request($urandom_range(1), $urandom);
          sent++;
        end
      end else begin
        run_frame(n);
        if ($urandom_range(1)) run_frame(n);
        sent += 2 * n;
      end
    end
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    stbl_res_t exp_pix;
    if (rst_ni && res_valid_o) begin
      if (pending_pixels.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", res_o);
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (res_o.pixel_out !== exp_pix.pixel_out || res_o.valid_res !== exp_pix.valid_res
            || res_o.last_pixel !== exp_pix.last_pixel) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("pixel mismatch: expected %h/%b/%b, got %h/%b/%b",
                     exp_pix.pixel_out, exp_pix.valid_res, exp_pix.last_pixel,
                     res_o.pixel_out, res_o.valid_res, res_o.last_pixel);
        end
      end
    end
  end

  // Stop the run when nothing moves for too long.
  always @(posedge clk_i) begin
    int unsigned stall_cnt;
    if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= StallMax) begin
      $display("** stack_blur_argb_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    width_reg   = 9'd256;
    height_reg  = 9'd256;
    radius_reg  = 6'd1;
    load_cnt    = 0;
    read_cnt    = 0;
    blurred     = 1'b0;
    mismatch_cnt = 0;
    idle_en     = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_frame();
    test_special_cases();
    test_extremes();
    test_random_frames();

    settle();
    if (mismatch_cnt == 0 && pending_pixels.size() == 0) begin
      $display("** stack_blur_argb_core: PASSED **");
    end else begin
      $display("** stack_blur_argb_core: FAILED **");
    end
    $finish;
  end

endmodule
